[sv/fa2_pkg.sv]
// shared types and constants for the fast atan2 phase block
`timescale 1ns / 1ps
`default_nettype none

package fa2_pkg;

    // width of the sample and angle fields on the ports
    localparam int FIELD_WIDTH = 16;

    // fractional bits of the internal angle format
    localparam int WORK_FRAC = 30;
    localparam int ANGLE_WIDTH = 32;

    // angle constants in the internal format
    localparam logic [ANGLE_WIDTH-1:0] PI_Q30      = 32'd3373259426;
    localparam logic [ANGLE_WIDTH-1:0] HALF_PI_Q30 = 32'd1686629713;

    // cubic coefficient 0.226 scaled by 2^16
    localparam int COEF_WIDTH = 14;
    localparam int COEF_SHIFT = 16;
    localparam logic [COEF_WIDTH-1:0] COEF_Q16 = 14'd14811;

    // rounding of the internal angle down to 13 fractional bits
    localparam int OUT_SHIFT = 17;
    localparam logic [ANGLE_WIDTH-1:0] ROUND_HALF = 32'd65536;

    // one input transaction
    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] x_in;
        logic signed [FIELD_WIDTH-1:0] y_in;
    } sample_t;

    // one result transaction
    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] angle;
        logic                          zero_input;
    } phase_t;

    // quadrant and special-case flags that follow a sample down the pipe
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic swap;
        logic zero;
    } side_t;

endpackage

`default_nettype wire

[sv/fast_atan2_phase_top.sv]
// fast atan2 phase: pipelined I/Q to phase angle converter
//
// sample channel: sample_valid / sample_stall carry one I/Q pair
// (x_in, y_in); a transaction completes on a clock edge with valid high
// and stall low. phase channel: phase_valid / phase_stall carry the
// angle (radians, 13 fractional bits) and the zero_input flag.
// one result comes out for every sample, in order.
// throughput: one sample per clock while phase_stall is low. pipeline: one
// magnitude stage, the ratio divider at two quotient bits per stage, three
// multiplier stages and two stages of quadrant mapping and rounding.
// reset empties every stage; nothing in flight survives it.
// when the receiver stalls, the finished result holds on the phase port and
// the stages behind it keep filling bubbles; sample_stall rises only once
// every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module fast_atan2_phase_top #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int RATIO_FRAC_BITS = 15
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire fa2_pkg::sample_t  sample,
    output logic                   phase_valid,
    input  wire logic              phase_stall,
    output fa2_pkg::phase_t        phase
);
    import fa2_pkg::*;

    localparam int MW  = SAMPLE_WIDTH - 1;
    localparam int QW  = RATIO_FRAC_BITS + 1;
    localparam int EXW = FIELD_WIDTH + SAMPLE_WIDTH;
    // square of the ratio rescaled to the working format
    localparam int SH_L = (2 * RATIO_FRAC_BITS < WORK_FRAC) ?
                          WORK_FRAC - 2 * RATIO_FRAC_BITS : 0;
    localparam int SH_R = (2 * RATIO_FRAC_BITS >= WORK_FRAC) ?
                          2 * RATIO_FRAC_BITS - WORK_FRAC : 0;
    localparam int SQW  = 2 * QW + SH_L;
    localparam int R2W  = WORK_FRAC + 1;
    localparam int P3W  = R2W + QW;
    localparam int PTW  = R2W + COEF_WIDTH;
    localparam int TW   = WORK_FRAC;
    localparam int R30_SHIFT = WORK_FRAC - RATIO_FRAC_BITS;

    // magnitude with the most negative code saturated
    function automatic logic [MW-1:0] mag_of(input logic [SAMPLE_WIDTH-1:0] v);
        logic [SAMPLE_WIDTH-1:0] n;
        n = -v;
        if (!v[SAMPLE_WIDTH-1]) begin
            return v[MW-1:0];
        end
        else if (v == {1'b1, {MW{1'b0}}}) begin
            return '1;
        end
        else begin
            return n[MW-1:0];
        end
    endfunction

    // magnitude stage
    logic [EXW-1:0]          x_ext;
    logic [EXW-1:0]          y_ext;
    logic [SAMPLE_WIDTH-1:0] xv;
    logic [SAMPLE_WIDTH-1:0] yv;
    logic [MW-1:0]           ax;
    logic [MW-1:0]           ay;
    logic                    mag_vld_reg;
    logic [MW-1:0]           lo_reg;
    logic [MW-1:0]           hi_reg;
    side_t                   mag_side_reg;
    side_t                   mag_side_next;
    logic                    mag_rdy;

    // divider outputs
    logic          div_stall;
    logic          div_vld;
    logic [QW-1:0] div_quo;
    side_t         div_side;

    // polynomial and mapping stages
    logic                   sq_vld_reg;
    logic [QW-1:0]          sq_r_reg;
    logic [R2W-1:0]         sq_r2_reg;
    side_t                  sq_side_reg;
    logic                   sq_rdy;
    logic [2*QW-1:0]        sq_prod;

    logic                   cu_vld_reg;
    logic [QW-1:0]          cu_r_reg;
    logic [R2W-1:0]         cu_r3_reg;
    side_t                  cu_side_reg;
    logic                   cu_rdy;
    logic [P3W-1:0]         cu_prod;

    logic                   tm_vld_reg;
    logic [ANGLE_WIDTH-1:0] tm_r30_reg;
    logic [TW-1:0]          tm_term_reg;
    side_t                  tm_side_reg;
    logic                   tm_rdy;
    logic [PTW-1:0]         tm_prod;

    logic                   oc_vld_reg;
    logic [ANGLE_WIDTH-1:0] oc_a_reg;
    logic [ANGLE_WIDTH-1:0] oc_a_next;
    side_t                  oc_side_reg;
    logic                   oc_rdy;

    logic                   out_vld_reg;
    phase_t                 out_reg;
    phase_t                 out_next;
    logic                   out_rdy;
    logic [ANGLE_WIDTH-1:0] qa;
    logic [ANGLE_WIDTH-1:0] rounded;
    logic [FIELD_WIDTH-1:0] mag16;

    // low sample bits of each field, zero-extended where the field is short
    assign x_ext = {{SAMPLE_WIDTH{1'b0}}, sample.x_in};
    assign y_ext = {{SAMPLE_WIDTH{1'b0}}, sample.y_in};
    assign xv    = x_ext[SAMPLE_WIDTH-1:0];
    assign yv    = y_ext[SAMPLE_WIDTH-1:0];
    assign ax    = mag_of(xv);
    assign ay    = mag_of(yv);

    always_comb begin
        mag_side_next.x_neg = xv[SAMPLE_WIDTH-1];
        mag_side_next.y_neg = yv[SAMPLE_WIDTH-1];
        mag_side_next.swap  = ay > ax;
        mag_side_next.zero  = (ax == '0) && (ay == '0);
    end

    // handshake chain from the output register back to the input
    assign out_rdy      = !out_vld_reg || !phase_stall;
    assign oc_rdy       = !oc_vld_reg || out_rdy;
    assign tm_rdy       = !tm_vld_reg || oc_rdy;
    assign cu_rdy       = !cu_vld_reg || tm_rdy;
    assign sq_rdy       = !sq_vld_reg || cu_rdy;
    assign mag_rdy      = !mag_vld_reg || !div_stall;
    assign sample_stall = !mag_rdy;

    // valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mag_vld_reg <= 1'b0;
            sq_vld_reg  <= 1'b0;
            cu_vld_reg  <= 1'b0;
            tm_vld_reg  <= 1'b0;
            oc_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else begin
            if (mag_rdy) begin
                mag_vld_reg <= sample_valid;
            end
            if (sq_rdy) begin
                sq_vld_reg <= div_vld;
            end
            if (cu_rdy) begin
                cu_vld_reg <= sq_vld_reg;
            end
            if (tm_rdy) begin
                tm_vld_reg <= cu_vld_reg;
            end
            if (oc_rdy) begin
                oc_vld_reg <= tm_vld_reg;
            end
            if (out_rdy) begin
                out_vld_reg <= oc_vld_reg;
            end
        end
    end

    // magnitude stage payload: order the magnitudes
    always_ff @(posedge clk) begin
        if (mag_rdy && sample_valid) begin
            lo_reg       <= mag_side_next.swap ? ax : ay;
            hi_reg       <= mag_side_next.swap ? ay : ax;
            mag_side_reg <= mag_side_next;
        end
    end

    // ratio lo / hi with RATIO_FRAC_BITS fractional bits
    fa2_div #(
        .MAG_WIDTH (MW),
        .QUO_WIDTH (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mag_vld_reg),
        .up_stall (div_stall),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .up_side  (mag_side_reg),
        .dn_valid (div_vld),
        .dn_stall (!sq_rdy),
        .quo      (div_quo),
        .dn_side  (div_side)
    );

    // square of the ratio in the working format
    assign sq_prod = {{QW{1'b0}}, div_quo} * {{QW{1'b0}}, div_quo};
    always_ff @(posedge clk) begin
        if (sq_rdy && div_vld) begin
            sq_r_reg    <= div_quo;
            sq_r2_reg   <= R2W'((SQW'(sq_prod) << SH_L) >> SH_R);
            sq_side_reg <= div_side;
        end
    end

    // cube of the ratio
    assign cu_prod = P3W'(sq_r2_reg) * P3W'(sq_r_reg);
    always_ff @(posedge clk) begin
        if (cu_rdy && sq_vld_reg) begin
            cu_r_reg    <= sq_r_reg;
            cu_r3_reg   <= R2W'(cu_prod >> RATIO_FRAC_BITS);
            cu_side_reg <= sq_side_reg;
        end
    end

    // cubic correction term and ratio in the working format
    assign tm_prod = PTW'(cu_r3_reg) * PTW'(COEF_Q16);
    always_ff @(posedge clk) begin
        if (tm_rdy && cu_vld_reg) begin
            tm_r30_reg  <= ANGLE_WIDTH'(cu_r_reg) << R30_SHIFT;
            tm_term_reg <= TW'(tm_prod >> COEF_SHIFT);
            tm_side_reg <= cu_side_reg;
        end
    end

    // first octant angle, reflected about pi/4 when |y| > |x|
    always_comb begin
        oc_a_next = tm_r30_reg - ANGLE_WIDTH'(tm_term_reg);
        if (tm_side_reg.swap) begin
            oc_a_next = HALF_PI_Q30 - oc_a_next;
        end
    end

    always_ff @(posedge clk) begin
        if (oc_rdy && tm_vld_reg) begin
            oc_a_reg    <= oc_a_next;
            oc_side_reg <= tm_side_reg;
        end
    end

    // left half-plane, rounding and sign
    always_comb begin
        qa      = oc_side_reg.x_neg ? (PI_Q30 - oc_a_reg) : oc_a_reg;
        rounded = qa + ROUND_HALF;
        mag16   = FIELD_WIDTH'(rounded[ANGLE_WIDTH-1:OUT_SHIFT]);
        if (oc_side_reg.zero) begin
            out_next.angle      = '0;
            out_next.zero_input = 1'b1;
        end
        else begin
            out_next.angle      = oc_side_reg.y_neg ? -mag16 : mag16;
            out_next.zero_input = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk) begin
        if (out_rdy && oc_vld_reg) begin
            out_reg <= out_next;
        end
    end

    assign phase_valid = out_vld_reg;
    assign phase       = out_reg;

endmodule

`default_nettype wire

[sv/fa2_div.sv]
// pipelined restoring divider for the magnitude ratio
`timescale 1ns / 1ps
`default_nettype none

module fa2_div #(
    parameter int MAG_WIDTH = 15,
    parameter int QUO_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_stall,
    input  wire logic [MAG_WIDTH-1:0]  lo,
    input  wire logic [MAG_WIDTH-1:0]  hi,
    input  wire fa2_pkg::side_t        up_side,
    output logic                       dn_valid,
    input  wire logic                  dn_stall,
    output logic [QUO_WIDTH-1:0]       quo,
    output fa2_pkg::side_t             dn_side
);
    import fa2_pkg::*;

    // quotient bits resolved in one stage
    localparam int PER_STAGE = 2;
    localparam int STAGES = (QUO_WIDTH + PER_STAGE - 1) / PER_STAGE;
    localparam int STEP_WIDTH = MAG_WIDTH + QUO_WIDTH;

    // stage registers
    logic [STAGES-1:0]    vld_reg;
    logic [MAG_WIDTH-1:0] rem_reg  [STAGES];
    logic [MAG_WIDTH-1:0] hi_reg   [STAGES];
    logic [QUO_WIDTH-1:0] quo_reg  [STAGES];
    side_t                side_reg [STAGES];

    // next values
    logic [MAG_WIDTH-1:0] rem_next [STAGES];
    logic [QUO_WIDTH-1:0] quo_next [STAGES];
    logic [STAGES-1:0]    src_vld;
    logic [STAGES-1:0]    rdy;

    // a group of quotient steps; the first step compares without shifting
    function automatic logic [STEP_WIDTH-1:0] div_steps(
        input logic [MAG_WIDTH-1:0] rem_i,
        input logic [MAG_WIDTH-1:0] hi_i,
        input logic [QUO_WIDTH-1:0] quo_i,
        input int                   base
    );
        logic [MAG_WIDTH:0]   t;
        logic [MAG_WIDTH-1:0] r;
        logic [QUO_WIDTH-1:0] q;
        r = rem_i;
        q = quo_i;
        for (int k = 0; k < PER_STAGE; k++) begin
            if (base + k < QUO_WIDTH) begin
                if (base + k == 0) begin
                    t = {1'b0, r};
                end
                else begin
                    t = {r, 1'b0};
                end
                if (t >= {1'b0, hi_i}) begin
                    t = t - {1'b0, hi_i};
                    q = {q[QUO_WIDTH-2:0], 1'b1};
                end
                else begin
                    q = {q[QUO_WIDTH-2:0], 1'b0};
                end
                r = t[MAG_WIDTH-1:0];
            end
        end
        return {r, q};
    endfunction

    // quotient steps for every stage
    always_comb begin
        logic [STEP_WIDTH-1:0] res;
        res = div_steps(lo, hi, '0, 0);
        rem_next[0] = res[STEP_WIDTH-1:QUO_WIDTH];
        quo_next[0] = res[QUO_WIDTH-1:0];
        src_vld[0]  = up_valid;
        for (int s = 1; s < STAGES; s++) begin
            res = div_steps(rem_reg[s-1], hi_reg[s-1], quo_reg[s-1], s * PER_STAGE);
            rem_next[s] = res[STEP_WIDTH-1:QUO_WIDTH];
            quo_next[s] = res[QUO_WIDTH-1:0];
            src_vld[s]  = vld_reg[s-1];
        end
    end

    // a stage takes new data when empty or when the next one moves
    always_comb begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !dn_stall;
        for (int s = STAGES - 2; s >= 0; s--) begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            for (int s = 0; s < STAGES; s++) begin
                if (rdy[s]) begin
                    vld_reg[s] <= src_vld[s];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk) begin
        if (rdy[0] && up_valid) begin
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
            hi_reg[0]   <= hi;
            side_reg[0] <= up_side;
        end
        for (int s = 1; s < STAGES; s++) begin
            if (rdy[s] && vld_reg[s-1]) begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                hi_reg[s]   <= hi_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign up_stall = !rdy[0];
    assign dn_valid = vld_reg[STAGES-1];
    assign quo      = quo_reg[STAGES-1];
    assign dn_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire
